// ----- hdl/frc_pkg.sv -----
`timescale 1ns / 1ps
package frc_pkg;

  localparam int MAX_RULES = 64;
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int HIT_W = 6;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  localparam logic [1:0] PROTO_OTHER = 2'd2;
  localparam logic [1:0] DIR_ANY     = 2'd2;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_MASK   = 2'd1;
  localparam logic [1:0] KIND_RANGE  = 2'd2;

  localparam logic [1:0] SIDE_LOCAL  = 2'd0;
  localparam logic [1:0] SIDE_REMOTE = 2'd1;
  localparam logic [1:0] SIDE_EITHER = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [31:0] addr_b;
    logic [31:0] addr_a;
  } addr_word_t;

  typedef struct packed {
    logic [1:0]  port_side;
    logic [1:0]  port_kind;
    logic [1:0]  addr_side;
    logic [1:0]  addr_kind;
    logic [1:0]  dir;
    logic [1:0]  proto;
    logic [15:0] port_b;
    logic [15:0] port_a;
  } mode_word_t;

  typedef struct packed {
    addr_word_t aw;
    mode_word_t mw;
  } rule_t;

  // operands of a connection check
  typedef struct packed {
    logic [1:0]  proto;
    logic [1:0]  dir;
    logic [31:0] addr_l;
    logic [31:0] addr_r;
    logic [15:0] port_l;
    logic [15:0] port_r;
  } chk_t;

endpackage

// ----- hdl/frc_rule_mem.sv -----
`timescale 1ns / 1ps
module frc_rule_mem (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [frc_pkg::IDX_W-1:0] wr_idx,
  input  frc_pkg::rule_t           wr_rule,
  input  logic [frc_pkg::IDX_W-1:0] rd_idx,
  output frc_pkg::rule_t           rd_rule
);
  import frc_pkg::*;

  addr_word_t addr_mem [MAX_RULES];
  mode_word_t mode_mem [MAX_RULES];
  addr_word_t rd_aw_r;
  mode_word_t rd_mw_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_rule.aw;
    end
    rd_aw_r <= addr_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mode_mem[wr_idx] <= wr_rule.mw;
    end
    rd_mw_r <= mode_mem[rd_idx];
  end

  assign rd_rule.aw = rd_aw_r;
  assign rd_rule.mw = rd_mw_r;

endmodule

// ----- hdl/frc_match.sv -----
`timescale 1ns / 1ps
module frc_match (
  input  frc_pkg::rule_t rule,
  input  frc_pkg::chk_t  chk,
  output logic           hit
);
  import frc_pkg::*;

  logic addr_l_ok, addr_r_ok, port_l_ok, port_r_ok;
  logic addr_ok, port_ok, proto_ok, dir_ok;

  always_comb begin
    case (rule.mw.addr_kind)
      KIND_SINGLE: begin
        addr_l_ok = (chk.addr_l == rule.aw.addr_a);
        addr_r_ok = (chk.addr_r == rule.aw.addr_a);
      end
      KIND_MASK: begin
        addr_l_ok = ((chk.addr_l & rule.aw.addr_b) == (rule.aw.addr_a & rule.aw.addr_b));
        addr_r_ok = ((chk.addr_r & rule.aw.addr_b) == (rule.aw.addr_a & rule.aw.addr_b));
      end
      KIND_RANGE: begin
        addr_l_ok = (rule.aw.addr_a <= chk.addr_l) && (chk.addr_l <= rule.aw.addr_b);
        addr_r_ok = (rule.aw.addr_a <= chk.addr_r) && (chk.addr_r <= rule.aw.addr_b);
      end
      default: begin
        addr_l_ok = 1'b0;
        addr_r_ok = 1'b0;
      end
    endcase
  end

  // port mask kind never matches
  always_comb begin
    case (rule.mw.port_kind)
      KIND_SINGLE: begin
        port_l_ok = (chk.port_l == rule.mw.port_a);
        port_r_ok = (chk.port_r == rule.mw.port_a);
      end
      KIND_RANGE: begin
        port_l_ok = (rule.mw.port_a <= chk.port_l) && (chk.port_l <= rule.mw.port_b);
        port_r_ok = (rule.mw.port_a <= chk.port_r) && (chk.port_r <= rule.mw.port_b);
      end
      default: begin
        port_l_ok = 1'b0;
        port_r_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (rule.mw.addr_side)
      SIDE_LOCAL:  addr_ok = addr_l_ok;
      SIDE_REMOTE: addr_ok = addr_r_ok;
      SIDE_EITHER: addr_ok = addr_l_ok | addr_r_ok;
      default:     addr_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (rule.mw.port_side)
      SIDE_LOCAL:  port_ok = port_l_ok;
      SIDE_REMOTE: port_ok = port_r_ok;
      SIDE_EITHER: port_ok = port_l_ok | port_r_ok;
      default:     port_ok = 1'b0;
    endcase
  end

  assign proto_ok = (rule.mw.proto == chk.proto);
  assign dir_ok   = (rule.mw.dir == DIR_ANY) || (rule.mw.dir == chk.dir);
  assign hit      = proto_ok & dir_ok & addr_ok & port_ok;

endmodule

// ----- hdl/firewall_rule_classifier.sv -----
`timescale 1ns / 1ps
// append, clear, unknown commands, and checks on an empty table or with proto
// other or above: the result strobes in the cycle after start is taken, busy
// stays low, one word per cycle. check: busy; rules are read one per cycle in
// index order through the read register; first hit or last rule ends the scan.
// synchronous active-low reset empties the table and idles the scan; the rule
// memory itself is not cleared. the receiver cannot stall the result strobe.
module firewall_rule_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_proto,
  input  logic [1:0]  in_dir,
  input  logic [31:0] in_addr_a,
  input  logic [31:0] in_addr_b,
  input  logic [15:0] in_port_a,
  input  logic [15:0] in_port_b,
  input  logic [1:0]  in_addr_kind,
  input  logic [1:0]  in_addr_side,
  input  logic [1:0]  in_port_kind,
  input  logic [1:0]  in_port_side,
  output logic        out_valid,
  output logic        out_blocked,
  output logic [5:0]  out_hit_index,
  output logic        out_status
);
  import frc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] rule_count_r, rule_count_nxt;
  logic [CNT_W-1:0] issue_cnt_r, issue_cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_last_r;
  chk_t             chk_r, chk_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_blocked_r, out_blocked_nxt;
  logic [HIT_W-1:0] out_hit_r, out_hit_nxt;
  logic             out_status_r, out_status_nxt;

  logic             accept;
  logic             table_full;
  logic             issue;
  logic             wr_en;
  rule_t            wr_rule;
  rule_t            rd_rule;
  logic             rule_hit;
  logic             scan_done;

  assign accept     = start & (state_r == S_IDLE);
  assign table_full = (rule_count_r >= CNT_W'(MAX_RULES));
  assign issue      = (state_r == S_SCAN) && (issue_cnt_r < rule_count_r);
  assign wr_en      = accept && (in_cmd == CMD_APPEND) && !table_full;
  assign scan_done  = rd_vld_r && (rule_hit || rd_last_r);

  always_comb begin
    wr_rule.aw.addr_a    = in_addr_a;
    wr_rule.aw.addr_b    = in_addr_b;
    wr_rule.mw.port_a    = in_port_a;
    wr_rule.mw.port_b    = in_port_b;
    wr_rule.mw.proto     = in_proto;
    wr_rule.mw.dir       = in_dir;
    wr_rule.mw.addr_kind = in_addr_kind;
    wr_rule.mw.addr_side = in_addr_side;
    wr_rule.mw.port_kind = in_port_kind;
    wr_rule.mw.port_side = in_port_side;
  end

  frc_rule_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (rule_count_r[IDX_W-1:0]),
    .wr_rule (wr_rule),
    .rd_idx  (issue_cnt_r[IDX_W-1:0]),
    .rd_rule (rd_rule)
  );

  frc_match u_match (
    .rule (rd_rule),
    .chk  (chk_r),
    .hit  (rule_hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_CHECK) && (in_proto < PROTO_OTHER) &&
            (rule_count_r != '0)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    rule_count_nxt  = rule_count_r;
    issue_cnt_nxt   = issue_cnt_r;
    rd_vld_nxt      = 1'b0;
    chk_nxt         = chk_r;
    out_valid_nxt   = 1'b0;
    out_blocked_nxt = 1'b0;
    out_hit_nxt     = '0;
    out_status_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        issue_cnt_nxt = '0;
        chk_nxt.proto  = in_proto;
        chk_nxt.dir    = in_dir;
        chk_nxt.addr_l = in_addr_a;
        chk_nxt.addr_r = in_addr_b;
        chk_nxt.port_l = in_port_a;
        chk_nxt.port_r = in_port_b;
        if (accept) begin
          case (in_cmd)
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_status_nxt = 1'b1;
              end else begin
                rule_count_nxt = rule_count_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              out_valid_nxt  = 1'b1;
              rule_count_nxt = '0;
            end
            CMD_CHECK: begin
              // nothing to scan: answer at once
              out_valid_nxt = (in_proto >= PROTO_OTHER) || (rule_count_r == '0);
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
          rd_vld_nxt    = !scan_done;
        end
        if (scan_done) begin
          out_valid_nxt   = 1'b1;
          out_blocked_nxt = rule_hit;
          out_hit_nxt     = rule_hit ? HIT_W'(rd_idx_r) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rule_count_r <= '0;
      issue_cnt_r  <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rule_count_r <= rule_count_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r         <= chk_nxt;
    rd_idx_r      <= issue_cnt_r[IDX_W-1:0];
    rd_last_r     <= (issue_cnt_r == (rule_count_r - CNT_W'(1)));
    out_blocked_r <= out_blocked_nxt;
    out_hit_r     <= out_hit_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_blocked   = out_blocked_r;
  assign out_hit_index = out_hit_r;
  assign out_status    = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rule_count_r <= CNT_W'(MAX_RULES))
    else $error("rule count above table size");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(rule_count_r))
    else $error("rule count changed during a scan");

  a_rd_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("read data flagged valid outside a scan");

  a_rd_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ({1'b0, rd_idx_r} < rule_count_r))
    else $error("scan read beyond stored rules");

  a_blocked_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_blocked) |-> !out_status)
    else $error("blocked result carries table-full status");

endmodule
